### rtl/opi_pkg.sv
// ----------------------------------------------------------------------------
// opi_pkg
// Shared types and constants of the odometry pose integrator.
// ----------------------------------------------------------------------------
package opi_pkg;

   localparam int CSR_W     = 16;
   localparam int COUNT_W   = 32;
   localparam int TURN_W    = 32;
   localparam int ZW        = TURN_W + 1;
   localparam int ITER_W    = 5;
   localparam int GUARD_BITS = 8;
   localparam int LO_BITS   = 24;
   localparam int MUL_OP_W  = LO_BITS + 1;
   localparam int GAIN_W    = 31;
   localparam int PROD_W    = MUL_OP_W + GAIN_W;
   localparam int GAIN_SHIFT = 22;
   localparam int MUL_STEPS = 4;

   localparam logic signed [GAIN_W-1:0] GAIN_Q30 = 31'sd652032874;
   localparam logic signed [TURN_W-1:0] QUARTER_TURN = 32'sh4000_0000;
   localparam logic signed [TURN_W-1:0] NEG_QUARTER_TURN = -32'sh4000_0000;
   localparam logic [TURN_W-1:0] HALF_TURN = 32'h8000_0000;

   localparam logic [CSR_W-1:0] KF_INTERVAL_RESET = 16'd10;

   localparam logic [1:0] MUL_DX_LO = 2'd0;
   localparam logic [1:0] MUL_DX_HI = 2'd1;
   localparam logic [1:0] MUL_DY_LO = 2'd2;
   localparam logic [1:0] MUL_DY_HI = 2'd3;

   localparam logic ROT_GLOBAL = 1'b0;
   localparam logic ROT_WINDOW = 1'b1;

   typedef struct packed {
      logic              load;
      logic              mul_issue;
      logic [1:0]        mul_sel;
      logic              rot_init;
      logic              rot_step;
      logic              rot_done;
      logic              rot_sel;
      logic [ITER_W-1:0] iter;
      logic              out_load;
   } opi_cmd_type;

   // arctangent of 2^-i, full turn = 2^32
   function automatic logic [TURN_W-1:0] atan_turn(input logic [ITER_W-1:0] i);
      logic [TURN_W-1:0] v;
      case (i)
         5'd0:  v = 32'd536870912;
         5'd1:  v = 32'd316933406;
         5'd2:  v = 32'd167458907;
         5'd3:  v = 32'd85004756;
         5'd4:  v = 32'd42667331;
         5'd5:  v = 32'd21354465;
         5'd6:  v = 32'd10679838;
         5'd7:  v = 32'd5340245;
         5'd8:  v = 32'd2670163;
         5'd9:  v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

### rtl/opi_req_if.sv
// ----------------------------------------------------------------------------
// opi_req_if
// Odometry step channel: valid/ready with one planar step as payload.
// ----------------------------------------------------------------------------
interface opi_req_if #(
   parameter int POS_BITS   = 32,
   parameter int ANGLE_BITS = 16
) ();
   logic                         valid;
   logic                         ready;
   logic signed [POS_BITS-1:0]   odo_dx;
   logic signed [POS_BITS-1:0]   odo_dy;
   logic signed [ANGLE_BITS-1:0] odo_dturn;

   modport source (output valid, output odo_dx, output odo_dy, output odo_dturn,
                   input ready);
   modport sink   (input valid, input odo_dx, input odo_dy, input odo_dturn,
                   output ready);
endinterface

### rtl/opi_rsp_if.sv
// ----------------------------------------------------------------------------
// opi_rsp_if
// Pose result channel: valid/ready with the updated pose and keyframe data.
// ----------------------------------------------------------------------------
interface opi_rsp_if #(
   parameter int POS_BITS   = 32,
   parameter int ANGLE_BITS = 16
) ();
   logic                         valid;
   logic                         ready;
   logic signed [POS_BITS-1:0]   pose_x;
   logic signed [POS_BITS-1:0]   pose_y;
   logic signed [ANGLE_BITS-1:0] pose_heading;
   logic [31:0]                  node_index;
   logic                         keyframe_flag;
   logic [31:0]                  keyframe_index;
   logic signed [POS_BITS-1:0]   rel_x;
   logic signed [POS_BITS-1:0]   rel_y;
   logic signed [ANGLE_BITS-1:0] rel_heading;

   modport source (output valid, output pose_x, output pose_y, output pose_heading,
                   output node_index, output keyframe_flag, output keyframe_index,
                   output rel_x, output rel_y, output rel_heading, input ready);
   modport sink   (input valid, input pose_x, input pose_y, input pose_heading,
                   input node_index, input keyframe_flag, input keyframe_index,
                   input rel_x, input rel_y, input rel_heading, output ready);
endinterface

### rtl/opi_ctrl.sv
// ----------------------------------------------------------------------------
// opi_ctrl
// Sequencer: gain multiply, two cordic rotations, pose update, result load.
// ----------------------------------------------------------------------------
module opi_ctrl #(
   parameter int ROTATE_ITERS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output opi_pkg::opi_cmd_type cmd
);
   import opi_pkg::*;

   localparam int CNT_W = $clog2(ROTATE_ITERS);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_INIT = 3'd2;
   localparam logic [2:0] S_ITER = 3'd3;
   localparam logic [2:0] S_ACC  = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             sel_ff, sel_in;
   logic             rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      sel_in       = sel_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.rot_sel  = sel_ff;
      cmd.iter     = ITER_W'(cnt_ff);
      cmd.mul_sel  = cnt_ff[1:0];
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_issue = (cnt_ff != CNT_W'(MUL_STEPS));
            if (cnt_ff == CNT_W'(MUL_STEPS)) begin
               sel_in   = ROT_GLOBAL;
               state_in = S_INIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_INIT: begin
            cmd.rot_init = 1'b1;
            cnt_in       = '0;
            state_in     = S_ITER;
         end
         S_ITER: begin
            cmd.rot_step = 1'b1;
            if (cnt_ff == CNT_W'(ROTATE_ITERS - 1)) begin
               state_in = S_ACC;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_ACC: begin
            cmd.rot_done = 1'b1;
            if (sel_ff == ROT_GLOBAL) begin
               sel_in   = ROT_WINDOW;
               state_in = S_INIT;
            end else begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         sel_ff       <= ROT_GLOBAL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/opi_datapath.sv
// ----------------------------------------------------------------------------
// opi_datapath
// Gain multiplier, shared cordic rotator, pose accumulators and result regs.
// ----------------------------------------------------------------------------
module opi_datapath #(
   parameter int POS_BITS   = 32,
   parameter int ANGLE_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  opi_pkg::opi_cmd_type            cmd,
   input  logic signed [POS_BITS-1:0]      req_odo_dx,
   input  logic signed [POS_BITS-1:0]      req_odo_dy,
   input  logic signed [ANGLE_BITS-1:0]    req_odo_dturn,
   input  logic                            csr_wr_en,
   input  logic [opi_pkg::CSR_W-1:0]       csr_wr_data,
   output logic signed [POS_BITS-1:0]      rsp_pose_x,
   output logic signed [POS_BITS-1:0]      rsp_pose_y,
   output logic signed [ANGLE_BITS-1:0]    rsp_pose_heading,
   output logic [opi_pkg::COUNT_W-1:0]     rsp_node_index,
   output logic                            rsp_keyframe_flag,
   output logic [opi_pkg::COUNT_W-1:0]     rsp_keyframe_index,
   output logic signed [POS_BITS-1:0]      rsp_rel_x,
   output logic signed [POS_BITS-1:0]      rsp_rel_y,
   output logic signed [ANGLE_BITS-1:0]    rsp_rel_heading
);
   import opi_pkg::*;

   localparam int P  = POS_BITS;
   localparam int A  = ANGLE_BITS;
   localparam int AW = P + GAIN_W;
   localparam int CW = P + GUARD_BITS + 2;
   localparam int RW = CW - GUARD_BITS;
   localparam int SW = P + 3;

   localparam logic signed [CW-1:0] RND =
      {{(CW-GUARD_BITS){1'b0}}, 1'b1, {(GUARD_BITS-1){1'b0}}};
   localparam logic signed [SW-1:0] POS_MAX = {{(SW-P+1){1'b0}}, {(P-1){1'b1}}};
   localparam logic signed [SW-1:0] POS_MIN = ~POS_MAX;

   function automatic logic signed [P-1:0] sat_add(input logic signed [P-1:0] pos,
                                                   input logic signed [RW-1:0] d);
      logic signed [SW-1:0] s;
      logic signed [P-1:0]  r;
      s = SW'(pos) + SW'(d);
      if (s > POS_MAX) begin
         r = POS_MAX[P-1:0];
      end else if (s < POS_MIN) begin
         r = POS_MIN[P-1:0];
      end else begin
         r = s[P-1:0];
      end
      return r;
   endfunction

   // architectural state
   logic [CSR_W-1:0]       interval_ff, interval_in;
   logic signed [P-1:0]    glob_x_ff, glob_x_in, glob_y_ff, glob_y_in;
   logic [A-1:0]           glob_head_ff, glob_head_in;
   logic signed [P-1:0]    win_x_ff, win_x_in, win_y_ff, win_y_in;
   logic [A-1:0]           win_head_ff, win_head_in;
   logic [CSR_W-1:0]       win_steps_ff, win_steps_in;
   logic [COUNT_W-1:0]     node_cnt_ff, node_cnt_in;
   logic [COUNT_W-1:0]     kf_cnt_ff, kf_cnt_in;
   logic                   prod_vld_ff, prod_vld_in;

   // working registers
   logic signed [P-1:0]    dx_ff, dx_in, dy_ff, dy_in;
   logic [A-1:0]           dturn_ff, dturn_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [1:0]             prod_sel_ff, prod_sel_in;
   logic signed [AW-1:0]   acc_ff, acc_in;
   logic signed [CW-1:0]   gx_ff, gx_in, gy_ff, gy_in;
   logic signed [CW-1:0]   a_ff, a_in, b_ff, b_in;
   logic signed [ZW-1:0]   z_ff, z_in;

   // result registers
   logic signed [P-1:0]    o_pose_x_ff, o_pose_x_in, o_pose_y_ff, o_pose_y_in;
   logic [A-1:0]           o_pose_head_ff, o_pose_head_in;
   logic [COUNT_W-1:0]     o_node_ff, o_node_in;
   logic                   o_kf_ff, o_kf_in;
   logic [COUNT_W-1:0]     o_kf_idx_ff, o_kf_idx_in;
   logic signed [P-1:0]    o_rel_x_ff, o_rel_x_in, o_rel_y_ff, o_rel_y_in;
   logic [A-1:0]           o_rel_head_ff, o_rel_head_in;

   // combinational temporaries
   logic signed [P-1:0]        dx_hi, dy_hi;
   logic signed [MUL_OP_W-1:0] mul_op;
   logic signed [AW-1:0]       gain_sum, gain_shift;
   logic [A-1:0]               head_sel;
   logic [TURN_W-1:0]          zu;
   logic signed [TURN_W-1:0]   zs;
   logic signed [CW-1:0]       sa, sb;
   logic signed [ZW-1:0]       at;
   logic signed [CW-1:0]       ra, rb;
   logic signed [RW-1:0]       rx, ry;
   logic [CSR_W-1:0]           steps_nxt;
   logic                       kf;

   assign dx_hi = dx_ff >>> LO_BITS;
   assign dy_hi = dy_ff >>> LO_BITS;

   always_comb begin
      case (cmd.mul_sel)
         MUL_DX_LO: mul_op = $signed({1'b0, dx_ff[LO_BITS-1:0]});
         MUL_DX_HI: mul_op = MUL_OP_W'(dx_hi);
         MUL_DY_LO: mul_op = $signed({1'b0, dy_ff[LO_BITS-1:0]});
         MUL_DY_HI: mul_op = MUL_OP_W'(dy_hi);
         default:   mul_op = '0;
      endcase
   end

   assign gain_sum   = acc_ff + (AW'(prod_ff) <<< LO_BITS);
   assign gain_shift = gain_sum >>> GAIN_SHIFT;

   assign head_sel = (cmd.rot_sel == ROT_GLOBAL) ? glob_head_ff : win_head_ff;
   assign zu       = {head_sel, {(TURN_W-A){1'b0}}};
   assign zs       = $signed(zu);

   assign sa = a_ff >>> cmd.iter;
   assign sb = b_ff >>> cmd.iter;
   assign at = $signed({1'b0, atan_turn(cmd.iter)});

   assign ra = (a_ff + RND) >>> GUARD_BITS;
   assign rb = (b_ff + RND) >>> GUARD_BITS;
   assign rx = RW'(ra);
   assign ry = RW'(rb);

   assign steps_nxt = win_steps_ff + 1'b1;
   assign kf        = (steps_nxt >= interval_ff);

   always_comb begin
      interval_in    = interval_ff;
      glob_x_in      = glob_x_ff;
      glob_y_in      = glob_y_ff;
      glob_head_in   = glob_head_ff;
      win_x_in       = win_x_ff;
      win_y_in       = win_y_ff;
      win_head_in    = win_head_ff;
      win_steps_in   = win_steps_ff;
      node_cnt_in    = node_cnt_ff;
      kf_cnt_in      = kf_cnt_ff;
      prod_vld_in    = cmd.mul_issue;
      dx_in          = dx_ff;
      dy_in          = dy_ff;
      dturn_in       = dturn_ff;
      prod_in        = PROD_W'(mul_op) * PROD_W'(GAIN_Q30);
      prod_sel_in    = cmd.mul_sel;
      acc_in         = acc_ff;
      gx_in          = gx_ff;
      gy_in          = gy_ff;
      a_in           = a_ff;
      b_in           = b_ff;
      z_in           = z_ff;
      o_pose_x_in    = o_pose_x_ff;
      o_pose_y_in    = o_pose_y_ff;
      o_pose_head_in = o_pose_head_ff;
      o_node_in      = o_node_ff;
      o_kf_in        = o_kf_ff;
      o_kf_idx_in    = o_kf_idx_ff;
      o_rel_x_in     = o_rel_x_ff;
      o_rel_y_in     = o_rel_y_ff;
      o_rel_head_in  = o_rel_head_ff;

      if (csr_wr_en) begin
         interval_in = csr_wr_data;
      end

      if (cmd.load) begin
         dx_in    = req_odo_dx;
         dy_in    = req_odo_dy;
         dturn_in = req_odo_dturn;
      end

      // low half starts the sum, high half finishes it
      if (prod_vld_ff) begin
         case (prod_sel_ff)
            MUL_DX_LO, MUL_DY_LO: acc_in = AW'(prod_ff);
            MUL_DX_HI:            gx_in  = CW'(gain_shift);
            MUL_DY_HI:            gy_in  = CW'(gain_shift);
            default:              acc_in = acc_ff;
         endcase
      end

      // fold into the right half plane
      if (cmd.rot_init) begin
         if (zs > QUARTER_TURN || zs < NEG_QUARTER_TURN) begin
            a_in = -gx_ff;
            b_in = -gy_ff;
            z_in = ZW'($signed(zu ^ HALF_TURN));
         end else begin
            a_in = gx_ff;
            b_in = gy_ff;
            z_in = ZW'(zs);
         end
      end

      if (cmd.rot_step) begin
         if (!z_ff[ZW-1]) begin
            a_in = a_ff - sb;
            b_in = b_ff + sa;
            z_in = z_ff - at;
         end else begin
            a_in = a_ff + sb;
            b_in = b_ff - sa;
            z_in = z_ff + at;
         end
      end

      if (cmd.rot_done) begin
         if (cmd.rot_sel == ROT_GLOBAL) begin
            glob_x_in    = sat_add(glob_x_ff, rx);
            glob_y_in    = sat_add(glob_y_ff, ry);
            glob_head_in = glob_head_ff + dturn_ff;
         end else begin
            win_x_in    = sat_add(win_x_ff, rx);
            win_y_in    = sat_add(win_y_ff, ry);
            win_head_in = win_head_ff + dturn_ff;
         end
      end

      if (cmd.out_load) begin
         node_cnt_in    = node_cnt_ff + 1'b1;
         o_pose_x_in    = glob_x_ff;
         o_pose_y_in    = glob_y_ff;
         o_pose_head_in = glob_head_ff;
         o_node_in      = node_cnt_ff + 1'b1;
         o_kf_in        = kf;
         if (kf) begin
            kf_cnt_in     = kf_cnt_ff + 1'b1;
            o_kf_idx_in   = kf_cnt_ff + 1'b1;
            o_rel_x_in    = win_x_ff;
            o_rel_y_in    = win_y_ff;
            o_rel_head_in = win_head_ff;
            win_x_in      = '0;
            win_y_in      = '0;
            win_head_in   = '0;
            win_steps_in  = '0;
         end else begin
            o_kf_idx_in   = '0;
            o_rel_x_in    = '0;
            o_rel_y_in    = '0;
            o_rel_head_in = '0;
            win_steps_in  = steps_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff  <= KF_INTERVAL_RESET;
         glob_x_ff    <= '0;
         glob_y_ff    <= '0;
         glob_head_ff <= '0;
         win_x_ff     <= '0;
         win_y_ff     <= '0;
         win_head_ff  <= '0;
         win_steps_ff <= '0;
         node_cnt_ff  <= '0;
         kf_cnt_ff    <= '0;
         prod_vld_ff  <= 1'b0;
      end else begin
         interval_ff  <= interval_in;
         glob_x_ff    <= glob_x_in;
         glob_y_ff    <= glob_y_in;
         glob_head_ff <= glob_head_in;
         win_x_ff     <= win_x_in;
         win_y_ff     <= win_y_in;
         win_head_ff  <= win_head_in;
         win_steps_ff <= win_steps_in;
         node_cnt_ff  <= node_cnt_in;
         kf_cnt_ff    <= kf_cnt_in;
         prod_vld_ff  <= prod_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff          <= dx_in;
      dy_ff          <= dy_in;
      dturn_ff       <= dturn_in;
      prod_ff        <= prod_in;
      prod_sel_ff    <= prod_sel_in;
      acc_ff         <= acc_in;
      gx_ff          <= gx_in;
      gy_ff          <= gy_in;
      a_ff           <= a_in;
      b_ff           <= b_in;
      z_ff           <= z_in;
      o_pose_x_ff    <= o_pose_x_in;
      o_pose_y_ff    <= o_pose_y_in;
      o_pose_head_ff <= o_pose_head_in;
      o_node_ff      <= o_node_in;
      o_kf_ff        <= o_kf_in;
      o_kf_idx_ff    <= o_kf_idx_in;
      o_rel_x_ff     <= o_rel_x_in;
      o_rel_y_ff     <= o_rel_y_in;
      o_rel_head_ff  <= o_rel_head_in;
   end

   assign rsp_pose_x         = o_pose_x_ff;
   assign rsp_pose_y         = o_pose_y_ff;
   assign rsp_pose_heading   = $signed(o_pose_head_ff);
   assign rsp_node_index     = o_node_ff;
   assign rsp_keyframe_flag  = o_kf_ff;
   assign rsp_keyframe_index = o_kf_idx_ff;
   assign rsp_rel_x          = o_rel_x_ff;
   assign rsp_rel_y          = o_rel_y_ff;
   assign rsp_rel_heading    = $signed(o_rel_head_ff);

endmodule

### rtl/odometry_pose_integrator_keyframe_unit.sv
// ----------------------------------------------------------------------------
// odometry_pose_integrator_keyframe_unit
// Takes one step at a time: req is not ready again until the result of the
// previous step is loaded, as each step runs the gain multiply and the shared
// cordic rotator, once for the global pose and once for the window pose; a held
// rsp stalls the next step.
// Reset clears pose, window, counters and sets the keyframe interval to 10.
// ----------------------------------------------------------------------------
module odometry_pose_integrator_keyframe_unit #(
   parameter int POS_BITS     = 32,
   parameter int ANGLE_BITS   = 16,
   parameter int ROTATE_ITERS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   opi_req_if.sink                     req,
   opi_rsp_if.source                   rsp,
   input  logic                        csr_wr_en,
   input  logic [opi_pkg::CSR_W-1:0]   csr_wr_data
);
   import opi_pkg::*;

   opi_cmd_type cmd;

   opi_ctrl #(
      .ROTATE_ITERS (ROTATE_ITERS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   opi_datapath #(
      .POS_BITS   (POS_BITS),
      .ANGLE_BITS (ANGLE_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_odo_dx         (req.odo_dx),
      .req_odo_dy         (req.odo_dy),
      .req_odo_dturn      (req.odo_dturn),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_pose_x         (rsp.pose_x),
      .rsp_pose_y         (rsp.pose_y),
      .rsp_pose_heading   (rsp.pose_heading),
      .rsp_node_index     (rsp.node_index),
      .rsp_keyframe_flag  (rsp.keyframe_flag),
      .rsp_keyframe_index (rsp.keyframe_index),
      .rsp_rel_x          (rsp.rel_x),
      .rsp_rel_y          (rsp.rel_y),
      .rsp_rel_heading    (rsp.rel_heading)
   );

endmodule
